FILE: rtl/core/salc_pkg.sv
// Shared constants and types for the set-associative LRU cache model.
package salc_pkg;

    localparam int MAX_SETS = 256;
    localparam int MAX_WAYS = 8;
    localparam int SET_W    = $clog2(MAX_SETS);
    localparam int WAY_W    = $clog2(MAX_WAYS);
    localparam int RANK_W   = WAY_W;
    localparam int TAG_W    = 64;
    localparam int LINE_W   = SET_W + WAY_W;
    localparam int CFG_W    = 4;
    localparam int CNT_W    = 32;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_WAYS       = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

    // One set's bookkeeping: valid bit and recency rank per way.
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } salc_row_t;

    typedef struct packed {
        salc_row_t         row;
        logic [CFG_W-1:0]  ways;
        logic              hit;
        logic [WAY_W-1:0]  hit_way;
    } salc_lru_in_t;

    typedef struct packed {
        salc_row_t         row;
        logic              evict;
        logic [WAY_W-1:0]  target;
    } salc_lru_out_t;

endpackage

FILE: rtl/core/salc_tag_cmp.sv
// Tag store with registered read and the single shared tag comparator.
module salc_tag_cmp (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [salc_pkg::LINE_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [salc_pkg::LINE_W-1:0] wr_addr,
    input  logic [salc_pkg::TAG_W-1:0]  wr_data,
    input  logic [salc_pkg::TAG_W-1:0]  key,
    output logic                       match
);
    import salc_pkg::*;

    logic [TAG_W-1:0] tag_mem [MAX_SETS*MAX_WAYS];
    logic [TAG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= tag_mem[rd_addr];
        end
    end

    assign match = (rd_data_reg == key);

endmodule

FILE: rtl/core/salc_lru_calc.sv
// Victim choice and recency update for one set.
module salc_lru_calc (
    input  salc_pkg::salc_lru_in_t  lru_in,
    output salc_pkg::salc_lru_out_t lru_out
);
    import salc_pkg::*;

    logic              found;
    logic [WAY_W-1:0]  empty_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  target;
    logic [RANK_W-1:0] floor_rank;
    salc_row_t         row_new;

    always_comb begin
        // first empty way in use
        found     = 1'b0;
        empty_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if ((CFG_W'(i) < lru_in.ways) && !lru_in.row.valid[i]) begin
                found     = 1'b1;
                empty_way = WAY_W'(i);
            end
        end
        // lowest rank, first in way order on a tie
        victim = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if ((CFG_W'(i) < lru_in.ways) && (lru_in.row.rank[i] < lru_in.row.rank[victim])) begin
                victim = WAY_W'(i);
            end
        end

        if (lru_in.hit) begin
            target = lru_in.hit_way;
        end else if (found) begin
            target = empty_way;
        end else begin
            target = victim;
        end

        floor_rank = (!lru_in.hit && found) ? '0 : lru_in.row.rank[target];

        row_new = lru_in.row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if ((CFG_W'(i) < lru_in.ways) && (WAY_W'(i) != target) &&
                lru_in.row.valid[i] && (lru_in.row.rank[i] > floor_rank)) begin
                row_new.rank[i] = lru_in.row.rank[i] - RANK_W'(1);
            end
        end
        row_new.rank[target]  = RANK_W'(lru_in.ways - CFG_W'(1));
        row_new.valid[target] = 1'b1;

        lru_out.row    = row_new;
        lru_out.evict  = !lru_in.hit && !found;
        lru_out.target = target;
    end

endmodule

FILE: rtl/core/set_assoc_lru_cache_sim.sv
// Top level of the set-associative cache model with true LRU replacement.
//
//  Channel   Ports                     Payload (lowest bit first)
//  -------   -----------------------   ---------------------------------------------
//  input     s_tvalid/s_tready/s_tdata req_type[1:0], address[65:2], zero pad to 72
//  result    m_tvalid/m_tready/m_tdata was_hit, was_miss, was_evicted, modify_hit,
//                                      hit_total, miss_total, evict_total, pad to 104
//  config    cfg_we/cfg_addr/cfg_wdata 0 set_bits, 1 ways_in_use, 2 block_bits
//
// From transfer to result, an access reads the set's row, then for each way
// scanned (up to the first hit, at most ways_in_use) does a tag memory read and
// a compare in the shared unit, and then writes the row back. After reset the
// row memory is cleared one set per cycle, all 256 sets, with s_tready low. A
// finished result sits in the output register; the next access is taken while
// it waits, and only the write-back of that access stalls until the result is
// taken.
module set_assoc_lru_cache_sim (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [3:0]   cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // req_type[1:0], address[65:2]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // was_hit[0], was_miss[1], was_evicted[2],
                                    // modify_hit[3], hit_total[35:4],
                                    // miss_total[67:36], evict_total[99:68]
);
    import salc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW_RD,
        ST_TAG_RD,
        ST_TAG_CMP,
        ST_UPDATE
    } state_t;

    state_t              state_reg;
    logic [SET_W-1:0]    clr_cnt_reg;
    logic [CFG_W-1:0]    set_bits_reg;
    logic [CFG_W-1:0]    ways_reg;
    logic [CFG_W-1:0]    block_bits_reg;

    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    blk_reg;
    logic [1:0]          req_reg;
    logic [WAY_W-1:0]    way_reg;
    logic                hit_reg;
    logic [WAY_W-1:0]    hit_way_reg;
    salc_row_t           row_q_reg;

    logic [CNT_W-1:0]    hit_cnt_reg;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [CNT_W-1:0]    evict_cnt_reg;
    logic                m_tvalid_reg;
    logic                o_hit_reg;
    logic                o_miss_reg;
    logic                o_evict_reg;
    logic                o_modify_reg;

    salc_row_t           row_mem [MAX_SETS];

    logic [1:0]          in_req;
    logic [TAG_W-1:0]    in_addr;
    logic [TAG_W-1:0]    in_blk;
    logic [CFG_W-1:0]    sb_eff;
    logic [SET_W-1:0]    set_mask;
    logic [CFG_W-1:0]    ways_eff;
    logic                tag_match;
    logic                last_way;
    logic                out_free;
    logic                modify;
    salc_lru_in_t        lru_in;
    salc_lru_out_t       lru_out;

    assign in_req  = s_tdata[1:0];
    assign in_addr = s_tdata[65:2];
    assign in_blk  = in_addr >> block_bits_reg;

    // Clamp set bits to 12, then keep the index within the 256 sets.
    assign sb_eff   = (set_bits_reg > CFG_W'(12)) ? CFG_W'(12) : set_bits_reg;
    assign set_mask = (sb_eff >= CFG_W'(SET_W)) ? '1 :
                      SET_W'((9'd1 << sb_eff) - 9'd1);
    assign ways_eff = (ways_reg == '0) ? CFG_W'(1) :
                      (ways_reg > CFG_W'(MAX_WAYS)) ? CFG_W'(MAX_WAYS) : ways_reg;

    assign last_way = ({1'b0, way_reg} == (ways_eff - CFG_W'(1)));
    assign out_free = !m_tvalid_reg || m_tready;
    assign modify   = (req_reg == REQ_MODIFY);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, evict_cnt_reg, miss_cnt_reg, hit_cnt_reg,
                       o_modify_reg, o_evict_reg, o_miss_reg, o_hit_reg};

    salc_tag_cmp u_tag_cmp (
        .aclk    (aclk),
        .rd_en   (state_reg == ST_TAG_RD),
        .rd_addr ({set_reg, way_reg}),
        .wr_en   ((state_reg == ST_UPDATE) && out_free && !hit_reg),
        .wr_addr ({set_reg, lru_out.target}),
        .wr_data (blk_reg),
        .key     (blk_reg),
        .match   (tag_match)
    );

    assign lru_in.row     = row_q_reg;
    assign lru_in.ways    = ways_eff;
    assign lru_in.hit     = hit_reg;
    assign lru_in.hit_way = hit_way_reg;

    salc_lru_calc u_lru_calc (
        .lru_in  (lru_in),
        .lru_out (lru_out)
    );

    // Row memory: clearing pass after reset, one read per access, one write-back.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            row_mem[clr_cnt_reg] <= '0;
        end else if ((state_reg == ST_UPDATE) && out_free) begin
            row_mem[set_reg] <= lru_out.row;
        end
        if (state_reg == ST_ROW_RD) begin
            row_q_reg <= row_mem[set_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            set_bits_reg   <= CFG_W'(4);
            ways_reg       <= CFG_W'(1);
            block_bits_reg <= CFG_W'(4);
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // the user must write registers only while no access is in flight; the block does not enforce it
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_wdata;
                    CFG_WAYS:       ways_reg       <= cfg_wdata;
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_wdata;
                    default:        ;
                endcase
            end

            // drop valid on a taken result unless a new one loads this cycle
            if (m_tvalid_reg && m_tready && !((state_reg == ST_UPDATE) && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                    if (clr_cnt_reg == SET_W'(MAX_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg   <= in_req;
                        blk_reg   <= in_blk;
                        set_reg   <= in_blk[SET_W-1:0] & set_mask;
                        way_reg   <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= ST_ROW_RD;
                    end
                end
                ST_ROW_RD: begin
                    state_reg <= ST_TAG_RD;
                end
                ST_TAG_RD: begin
                    state_reg <= ST_TAG_CMP;
                end
                ST_TAG_CMP: begin
                    // stop at the first valid line whose tag matches
                    if (row_q_reg.valid[way_reg] && tag_match) begin
                        hit_reg     <= 1'b1;
                        hit_way_reg <= way_reg;
                        state_reg   <= ST_UPDATE;
                    end else if (last_way) begin
                        state_reg <= ST_UPDATE;
                    end else begin
                        way_reg   <= way_reg + WAY_W'(1);
                        state_reg <= ST_TAG_RD;
                    end
                end
                ST_UPDATE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        hit_cnt_reg   <= hit_cnt_reg + CNT_W'(hit_reg) + CNT_W'(modify);
                        miss_cnt_reg  <= miss_cnt_reg + CNT_W'(!hit_reg);
                        evict_cnt_reg <= evict_cnt_reg + CNT_W'(lru_out.evict);
                        o_hit_reg     <= hit_reg;
                        o_miss_reg    <= !hit_reg;
                        o_evict_reg   <= lru_out.evict;
                        o_modify_reg  <= modify;
                        m_tvalid_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/set_assoc_lru_cache_sim_tb.sv
`timescale 1ns / 1ps
// Testbench for the LRU cache model: directed and random accesses checked against a local cache predictor.
module set_assoc_lru_cache_sim_tb;
    import salc_pkg::*;

    localparam int NLINES       = MAX_SETS * MAX_WAYS;
    // Watchdog limit, set well above the slowest legal run.
    localparam int CYCLE_LIMIT  = 400_000;
    // Covers the worst access latency, rounded up for the tail.
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    // req_type 3 is not a named request; the block treats it as a load.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        bit             hit;
        bit             miss;
        bit             evicted;
        bit             modify_hit;
        bit [CNT_W-1:0] hits;
        bit [CNT_W-1:0] misses;
        bit [CNT_W-1:0] evicts;
    } access_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [3:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;   // req_type[1:0], address[65:2], zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // was_hit, was_miss, was_evicted, modify_hit,
                             // hit_total, miss_total, evict_total, zero pad

    set_assoc_lru_cache_sim dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow of every line plus the running totals and
    // the register values the block currently holds.
    // ------------------------------------------------------------------
    bit              shadow_valid [NLINES];
    bit [TAG_W-1:0]  shadow_tag   [NLINES];
    bit [RANK_W-1:0] shadow_rank  [NLINES];
    bit [CNT_W-1:0]  hit_cnt;
    bit [CNT_W-1:0]  miss_cnt;
    bit [CNT_W-1:0]  evict_cnt;
    bit [CFG_W-1:0]  cur_set_bits   = 4'd4;
    bit [CFG_W-1:0]  cur_ways       = 4'd1;
    bit [CFG_W-1:0]  cur_block_bits = 4'd4;

    access_result_t pending_results [$];

    int  errors;
    int  items_sent;
    int  configs_applied;
    int  cycle_count;
    bit  no_idle;        // suppress all random gaps on both sides
    bit  hold_results;   // ask the result side for one long stall

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: run exceeded %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Make one way most recent. Valid lines in use ranked above floor_rank
    // drop by one; a negative floor means every valid line above rank 0 drops.
    function automatic void promote(int base, int ways, int way, int floor_rank);
        for (int i = 0; i < ways; i++) begin
            if (i == way || !shadow_valid[base + i])
                continue;
            if (floor_rank < 0) begin
                if (shadow_rank[base + i] > 0)
                    shadow_rank[base + i]--;
            end else if (int'(shadow_rank[base + i]) > floor_rank) begin
                shadow_rank[base + i]--;
            end
        end
        shadow_rank[base + way]  = RANK_W'(ways - 1);
        shadow_valid[base + way] = 1'b1;
    endfunction

    // Look one access up in the shadow cache, update it, and return the
    // result the block must produce for it.
    function automatic access_result_t cache_lookup(logic [1:0] kind, logic [63:0] addr);
        access_result_t res;
        int             sb;
        int             ways;
        int             set_idx;
        int             base;
        int             slot;
        int             victim;
        logic [63:0]    blk;
        res = '{default: '0};
        // Clamp the registers the way the block does.
        sb   = (cur_set_bits > 12) ? 12 : int'(cur_set_bits);
        ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : int'(cur_ways));
        blk  = addr >> cur_block_bits;
        set_idx = int'((blk & ((64'd1 << sb) - 64'd1)) % 64'(MAX_SETS));
        base    = set_idx * MAX_WAYS;

        slot = -1;
        for (int i = 0; i < ways; i++)
            if (slot < 0 && shadow_valid[base + i] && shadow_tag[base + i] == blk)
                slot = i;

        if (slot >= 0) begin
            res.hit = 1'b1;
            promote(base, ways, slot, int'(shadow_rank[base + slot]));
        end else begin
            res.miss = 1'b1;
            // Fill the first empty way in use, else evict the lowest rank.
            for (int i = 0; i < ways; i++)
                if (slot < 0 && !shadow_valid[base + i])
                    slot = i;
            if (slot >= 0) begin
                shadow_tag[base + slot] = blk;
                promote(base, ways, slot, -1);
            end else begin
                victim = 0;
                for (int i = 1; i < ways; i++)
                    if (shadow_rank[base + i] < shadow_rank[base + victim])
                        victim = i;
                res.evicted = 1'b1;
                shadow_tag[base + victim] = blk;
                promote(base, ways, victim, int'(shadow_rank[base + victim]));
            end
        end

        hit_cnt   += res.hit;
        miss_cnt  += res.miss;
        evict_cnt += res.evicted;
        // The store half of a modify always hits.
        if (kind == REQ_MODIFY) begin
            res.modify_hit = 1'b1;
            hit_cnt++;
        end
        res.hits   = hit_cnt;
        res.misses = miss_cnt;
        res.evicts = evict_cnt;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 15);
        if (r < 5)
            return REQ_LOAD;
        if (r < 10)
            return REQ_STORE;
        if (r < 15)
            return REQ_MODIFY;
        return REQ_UNKNOWN;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one access after a random gap and hold it until the transfer.
    // The expectation is computed at the transfer edge, in acceptance order.
    task automatic send_access(logic [1:0] kind, logic [63:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, addr, kind};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(cache_lookup(kind, addr));
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has been checked,
    // then let the block finish its last write-back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back; only call while idle.
    task automatic set_config(bit [CFG_W-1:0] sb, bit [CFG_W-1:0] ways, bit [CFG_W-1:0] bb);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SET_BITS;
        cfg_wdata <= sb;
        @(posedge aclk);
        cfg_addr  <= CFG_WAYS;
        cfg_wdata <= ways;
        @(posedge aclk);
        cfg_addr  <= CFG_BLOCK_BITS;
        cfg_wdata <= bb;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_set_bits   = sb;
        cur_ways       = ways;
        cur_block_bits = bb;
        configs_applied++;
    endtask

    // Mostly accesses to a small working set of blocks so that lines get
    // reused and evicted; the rest are fully random addresses.
    task automatic send_mixed(int count, bit [CFG_W-1:0] bb);
        logic [63:0] pool [48];
        logic [63:0] region;
        logic [63:0] addr;
        int          pool_n;
        pool_n = $urandom_range(4, 48);
        region = {$urandom, $urandom};
        for (int i = 0; i < pool_n; i++)
            pool[i] = region + 64'($urandom_range(0, 1023));
        repeat (count) begin
            if ($urandom_range(0, 99) < 80)
                addr = (pool[$urandom_range(0, pool_n - 1)] << bb)
                       | ({$urandom, $urandom} & ((64'd1 << bb) - 64'd1));
            else
                addr = {$urandom, $urandom};
            send_access(pick_kind(), addr);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_results) begin
                // Hold off long enough for the block to fill and stall input.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("cycle %0d: %s: got %0h, want %0h", cycle_count, what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got != want)
            report_mismatch(what, 64'(got), 64'(want));
    endtask

    always @(posedge aclk) begin : result_check
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no access pending", m_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                check_field("was_hit",     32'(m_tdata[0]), 32'(want.hit));
                check_field("was_miss",    32'(m_tdata[1]), 32'(want.miss));
                check_field("was_evicted", 32'(m_tdata[2]), 32'(want.evicted));
                check_field("modify_hit",  32'(m_tdata[3]), 32'(want.modify_hit));
                check_field("hit_total",   m_tdata[35:4],   want.hits);
                check_field("miss_total",  m_tdata[67:36],  want.misses);
                check_field("evict_total", m_tdata[99:68],  want.evicts);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: 16 sets, one way, 16-byte blocks.
    // Cover every request kind, the unknown kind, and both address extremes.
    task automatic test_basic_ops();
        send_access(REQ_LOAD,    64'h0);                     // cold miss
        send_access(REQ_LOAD,    64'h0);                     // hit
        send_access(REQ_STORE,   64'hF);                     // same block, hit
        send_access(REQ_MODIFY,  64'h0);                     // hit plus store half
        send_access(REQ_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF);   // acts as a load, miss
        send_access(REQ_MODIFY,  64'hFFFF_FFFF_FFFF_FFFF);   // hit
        send_access(REQ_STORE,   64'h100);                   // conflict in set 0, evict
    endtask

    // One set of eight ways: fill it, overflow it once, then reuse.
    task automatic test_full_set_eviction();
        wait_drain();
        set_config(4'd0, 4'd8, 4'd0);
        for (int i = 1; i <= 9; i++)
            send_access(REQ_LOAD, 64'(i));
        send_access(REQ_LOAD,   64'd2);
        send_access(REQ_MODIFY, 64'd9);
    endtask

    // Shrink and regrow the ways in use so ranks go inconsistent, then the
    // out-of-range register values: set bits above 12, zero ways, ways
    // above the maximum, and set indexes that wrap past the last set.
    task automatic test_register_clamps();
        wait_drain();
        set_config(4'd0, 4'd3, 4'd0);
        send_access(REQ_LOAD, 64'd100);
        wait_drain();
        set_config(4'd0, 4'd8, 4'd0);
        send_access(REQ_LOAD, 64'd200);
        wait_drain();
        set_config(4'd15, 4'd0, 4'd15);
        send_access(REQ_LOAD, 64'h8000_0000);
        send_access(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drain();
        set_config(4'd12, 4'd15, 4'd9);
        send_access(REQ_STORE, 64'hF00 << 9);
        send_access(REQ_STORE, 64'h100 << 9);
        send_access(REQ_LOAD,  64'hF00 << 9);
    endtask

    // Random traffic over a spread of register settings, extremes included.
    task automatic test_random_mix();
        bit [CFG_W-1:0] plan [8][3];
        plan = '{'{4'd4,  4'd1, 4'd4}, '{4'd0, 4'd8, 4'd0}, '{4'd2, 4'd4, 4'd6},
                 '{4'd8,  4'd8, 4'd9}, '{4'd1, 4'd5, 4'd3}, '{4'd12, 4'd8, 4'd2},
                 '{4'd3,  4'd2, 4'd5}, '{4'd0, 4'd0, 4'd0}};
        // Last phase draws every register from its full 4-bit range.
        plan[7] = '{4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15))};
        for (int p = 0; p < 8; p++) begin
            wait_drain();
            set_config(plan[p][0], plan[p][1], plan[p][2]);
            // Run one phase with no gaps on either side.
            no_idle = (p == 2);
            send_mixed(60, plan[p][2]);
            no_idle = 1'b0;
        end
    endtask

    // Stall the result side for a long stretch while the input side keeps
    // offering back to back, so the block fills up and drops s_tready.
    task automatic test_backpressure();
        wait_drain();
        set_config(4'd3, 4'd2, 4'd5);
        no_idle      = 1'b1;
        hold_results = 1'b1;
        send_mixed(24, 4'd5);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_SET_BITS;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The block clears its row memory after reset; the first transfer
        // simply waits for s_tready.
        test_basic_ops();
        test_full_set_eviction();
        test_register_clamps();
        test_backpressure();
        test_random_mix();
        wait_drain();

        $display("covered %0d accesses under %0d register settings, one long result stall",
                 items_sent, configs_applied);
        $display("totals: %0d hits, %0d misses, %0d evictions", hit_cnt, miss_cnt, evict_cnt);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
